// ===== sv/bfa_pkg.sv =====
// Shared types and constants for the best-fit free-extent allocator.
// No dependencies; used by bfa_cell and the top level.
package bfa_pkg;

  localparam int MAX_EXTENTS_DEF = 64;
  localparam int PAGE_BITS_DEF   = 16;
  localparam int FIELD_W         = 16;
  localparam int STATUS_W        = 2;

  localparam logic [FIELD_W-1:0] HEAP_RESET = 16'd4096;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef logic [2:0] op_t;

  localparam op_t OP_HOLD   = 3'd0;
  localparam op_t OP_INIT   = 3'd1;
  localparam op_t OP_CAND   = 3'd2;
  localparam op_t OP_BIT    = 3'd3;
  localparam op_t OP_REMOVE = 3'd4;
  localparam op_t OP_UNDO   = 3'd5;
  localparam op_t OP_INSERT = 3'd6;
  localparam op_t OP_MERGE  = 3'd7;

  typedef struct packed {
    op_t  op;
    logic any_zero;
  } cell_cmd_t;

endpackage

// ===== sv/bfa_cell.sv =====
// One slot of the extent row: holds an extent, talks to its two neighbors.
// Depends on bfa_pkg.
module bfa_cell import bfa_pkg::*; #(
  parameter int PW    = PAGE_BITS_DEF,
  parameter int CW    = 16,
  parameter int BW    = 5,
  parameter bit FIRST = 1'b0
) (
  input  logic          clk,
  input  logic          rst,
  input  cell_cmd_t     cmd,
  input  logic [BW-1:0] bit_sel,
  input  logic [PW-1:0] key_start,
  input  logic [PW:0]   key_len,
  input  logic [CW-1:0] cnt,
  input  logic [PW:0]   init_len,
  input  logic          init_nz,
  input  logic          left_valid,
  input  logic [PW-1:0] left_start,
  input  logic [PW:0]   left_len,
  input  logic          right_valid,
  input  logic [PW-1:0] right_start,
  input  logic [PW:0]   right_len,
  input  logic          right_tag,
  input  logic          chain_in,
  output logic          chain_out,
  output logic          valid,
  output logic [PW-1:0] start,
  output logic [PW:0]   len,
  output logic          tag,
  output logic          cand,
  output logic          zb,
  output logic          touch,
  output logic [PW-1:0] sel_start,
  output logic [PW:0]   sel_len
);

  localparam int LW = PW + 1;

  logic gt;
  logic mark;
  logic sel;

  assign gt    = !valid || (start > key_start);
  assign touch = valid && right_valid && ((LW'(start) + len) == LW'(right_start));
  assign mark  = (cmd.op == OP_UNDO) ? tag : cand;
  assign sel   = mark && !chain_in;
  assign zb    = cand && !len[bit_sel];
  assign sel_start = sel ? start : '0;
  assign sel_len   = sel ? len : '0;

  always_comb begin
    unique case (cmd.op)
      OP_INSERT:           chain_out = gt;
      OP_MERGE:            chain_out = touch || chain_in;
      OP_REMOVE, OP_UNDO:  chain_out = mark || chain_in;
      default:             chain_out = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.op == OP_INIT) begin
      valid <= FIRST && init_nz;
      start <= '0;
      len   <= init_len;
      tag   <= 1'b0;
      cand  <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_CAND: cand <= valid && (CW'(len) >= cnt);
        OP_BIT: begin
          if (cmd.any_zero && len[bit_sel]) cand <= 1'b0;
        end
        OP_REMOVE, OP_UNDO: begin
          if (sel || chain_in) begin
            valid <= right_valid;
            start <= right_start;
            len   <= right_len;
            tag   <= right_tag;
          end
        end
        OP_INSERT: begin
          tag <= gt && !chain_in;
          if (gt && !chain_in) begin
            valid <= 1'b1;
            start <= key_start;
            len   <= key_len;
          end else if (gt) begin
            valid <= left_valid;
            start <= left_start;
            len   <= left_len;
          end
        end
        OP_MERGE: begin
          if (touch && !chain_in) begin
            len <= len + right_len;
          end else if (chain_in) begin
            valid <= right_valid;
            start <= right_start;
            len   <= right_len;
            tag   <= right_tag;
          end
        end
        OP_HOLD, OP_INIT: ;
      endcase
    end
  end

endmodule

// ===== sv/best_fit_free_list_allocator.sv =====
// Best-fit free-extent allocator, top level: control sequencer over a row of cells.
// Depends on bfa_pkg and bfa_cell.
//
// Free extents live in a row of MAX_EXTENTS+1 cells kept in start-page order; one
// request is worked on at a time. A free inserts its extent and then merges touching
// neighbors (a zero-length free goes straight to the response). An allocate finds the
// smallest fitting extent by a bit-serial minimum search over all cells, one length bit
// per cycle, removes it, and puts any remainder back into the row with the same insert
// and merge steps (a zero count is answered with no-fit). A full table on free backs out
// the insert. A held response stalls the sequencer until taken. A cfg_data write
// rebuilds the table and is taken only while no request is in flight.
module best_fit_free_list_allocator import bfa_pkg::*; #(
  parameter int MAX_EXTENTS     = MAX_EXTENTS_DEF,
  parameter int PAGE_INDEX_BITS = PAGE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [FIELD_W-1:0]                 cfg_data,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  logic                               req_type,
  input  logic [FIELD_W-1:0]                 start_page,
  input  logic [FIELD_W-1:0]                 page_count,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output logic [FIELD_W-1:0]                 granted_page,
  output logic [STATUS_W-1:0]                status,
  output logic [$clog2(MAX_EXTENTS+1)-1:0]   extent_count
);

  localparam int PW   = PAGE_INDEX_BITS;
  localparam int LW   = PW + 1;
  localparam int CW   = (LW > FIELD_W) ? LW : FIELD_W;
  localparam int BW   = $clog2(LW);
  localparam int NC   = MAX_EXTENTS + 1;
  localparam int NW   = $clog2(MAX_EXTENTS + 2);
  localparam int ECW  = $clog2(MAX_EXTENTS + 1);
  localparam logic [LW-1:0] SPACE_L = {1'b1, {PW{1'b0}}};
  localparam logic [CW-1:0] SPACE_C = CW'(SPACE_L);
  localparam logic [NW-1:0] MAX_N   = NW'(MAX_EXTENTS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CAND   = 3'd1;
  localparam logic [2:0] S_BIT    = 3'd2;
  localparam logic [2:0] S_PICK   = 3'd3;
  localparam logic [2:0] S_INSERT = 3'd4;
  localparam logic [2:0] S_MERGE  = 3'd5;
  localparam logic [2:0] S_UNDO   = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  logic [2:0]          state;
  logic [NW-1:0]       count;
  logic [CW-1:0]       cnt_r;
  logic [PW-1:0]       key_start;
  logic [LW-1:0]       key_len;
  logic [BW-1:0]       bitn;
  logic [PW-1:0]       granted;
  logic [STATUS_W-1:0] res_status;
  logic [FIELD_W-1:0]  rsp_granted;
  logic [STATUS_W-1:0] rsp_status;
  logic [ECW-1:0]      rsp_count;

  cell_cmd_t cmd;

  logic [NC-1:0] c_valid, c_tag, c_cand, c_zb, c_touch, c_chain;
  logic [PW-1:0] c_start [NC];
  logic [LW-1:0] c_len   [NC];
  logic [PW-1:0] c_sel_start [NC];
  logic [LW-1:0] c_sel_len   [NC];

  logic [FIELD_W-1:0] hp;
  logic [LW-1:0]      init_len;
  logic               init_nz;
  logic               any_zero, any_touch, found;
  logic [PW-1:0]      pick_start;
  logic [LW-1:0]      pick_len;
  logic [LW-1:0]      rem;
  logic [PW-1:0]      free_s;
  logic [LW-1:0]      free_lim;
  logic [LW-1:0]      free_l;
  logic               req_acc, cfg_acc, out_free;

  assign hp       = rst ? HEAP_RESET : cfg_data;
  assign init_len = (CW'(hp) > SPACE_C) ? SPACE_L : LW'(hp);
  assign init_nz  = (hp != '0);

  assign cfg_ready = (state == S_IDLE);
  assign req_ready = (state == S_IDLE) && !cfg_valid;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign req_acc   = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;

  assign free_s   = PW'(start_page);
  assign free_lim = SPACE_L - LW'(free_s);
  assign free_l   = (CW'(page_count) > CW'(free_lim)) ? free_lim : LW'(page_count);

  always_comb begin
    any_zero   = 1'b0;
    any_touch  = 1'b0;
    found      = 1'b0;
    pick_start = '0;
    pick_len   = '0;
    for (int i = 0; i < NC; i++) begin
      any_zero   = any_zero | c_zb[i];
      any_touch  = any_touch | c_touch[i];
      found      = found | c_cand[i];
      pick_start = pick_start | c_sel_start[i];
      pick_len   = pick_len | c_sel_len[i];
    end
  end

  assign rem = pick_len - LW'(cnt_r);

  always_comb begin
    cmd.any_zero = any_zero;
    unique case (state)
      S_IDLE:   cmd.op = cfg_valid ? OP_INIT : OP_HOLD;
      S_CAND:   cmd.op = OP_CAND;
      S_BIT:    cmd.op = OP_BIT;
      S_PICK:   cmd.op = found ? OP_REMOVE : OP_HOLD;
      S_INSERT: cmd.op = OP_INSERT;
      S_MERGE:  cmd.op = any_touch ? OP_MERGE : OP_HOLD;
      S_UNDO:   cmd.op = OP_UNDO;
      S_FIN:    cmd.op = OP_HOLD;
      default:  cmd.op = OP_HOLD;
    endcase
  end

  for (genvar i = 0; i < NC; i++) begin : g_cell
    logic          lv, rv, rt, ci;
    logic [PW-1:0] ls, rs;
    logic [LW-1:0] ll, rl;
    if (i == 0) begin : g_l0
      assign lv = 1'b0;
      assign ls = '0;
      assign ll = '0;
      assign ci = 1'b0;
    end else begin : g_ln
      assign lv = c_valid[i-1];
      assign ls = c_start[i-1];
      assign ll = c_len[i-1];
      assign ci = c_chain[i-1];
    end
    if (i == NC - 1) begin : g_r0
      assign rv = 1'b0;
      assign rs = '0;
      assign rl = '0;
      assign rt = 1'b0;
    end else begin : g_rn
      assign rv = c_valid[i+1];
      assign rs = c_start[i+1];
      assign rl = c_len[i+1];
      assign rt = c_tag[i+1];
    end
    bfa_cell #(.PW(PW), .CW(CW), .BW(BW), .FIRST(i == 0)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .bit_sel     (bitn),
      .key_start   (key_start),
      .key_len     (key_len),
      .cnt         (cnt_r),
      .init_len    (init_len),
      .init_nz     (init_nz),
      .left_valid  (lv),
      .left_start  (ls),
      .left_len    (ll),
      .right_valid (rv),
      .right_start (rs),
      .right_len   (rl),
      .right_tag   (rt),
      .chain_in    (ci),
      .chain_out   (c_chain[i]),
      .valid       (c_valid[i]),
      .start       (c_start[i]),
      .len         (c_len[i]),
      .tag         (c_tag[i]),
      .cand        (c_cand[i]),
      .zb          (c_zb[i]),
      .touch       (c_touch[i]),
      .sel_start   (c_sel_start[i]),
      .sel_len     (c_sel_len[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= NW'(init_nz);
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cfg_acc) begin
            count <= NW'(init_nz);
          end else if (req_acc) begin
            cnt_r      <= CW'(page_count);
            granted    <= '0;
            res_status <= (!req_type && page_count == '0) ? ST_NOFIT : ST_OK;
            key_start  <= free_s;
            key_len    <= free_l;
            bitn       <= BW'(LW - 1);
            if (req_type) begin
              state <= (free_l == '0) ? S_FIN : S_INSERT;
            end else if (page_count == '0) begin
              state <= S_FIN;
            end else begin
              state <= S_CAND;
            end
          end
        end
        S_CAND: state <= S_BIT;
        S_BIT: begin
          bitn <= bitn - BW'(1);
          if (bitn == '0) state <= S_PICK;
        end
        S_PICK: begin
          if (!found) begin
            res_status <= ST_NOFIT;
            state      <= S_FIN;
          end else begin
            count     <= count - NW'(1);
            granted   <= pick_start;
            key_start <= PW'(LW'(pick_start) + LW'(cnt_r));
            key_len   <= rem;
            state     <= (rem != '0) ? S_INSERT : S_FIN;
          end
        end
        S_INSERT: begin
          count <= count + NW'(1);
          state <= S_MERGE;
        end
        S_MERGE: begin
          if (any_touch) begin
            count <= count - NW'(1);
          end else if (count > MAX_N) begin
            state <= S_UNDO;
          end else begin
            state <= S_FIN;
          end
        end
        S_UNDO: begin
          count      <= count - NW'(1);
          res_status <= ST_FULL;
          state      <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            rsp_granted <= FIELD_W'(granted);
            rsp_status  <= res_status;
            rsp_count   <= ECW'(count);
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign granted_page = rsp_granted;
  assign status       = rsp_status;
  assign extent_count = rsp_count;

`ifndef SYNTHESIS
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> count == NW'($countones(c_valid)))
    else $error("extent count out of step with cell row");

  a_spare_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !c_valid[NC-1])
    else $error("spare cell holds an extent while idle");

  a_undo_tag: assert property (@(posedge clk) disable iff (rst)
    state == S_UNDO |-> $onehot(c_tag))
    else $error("back-out without a single marked item");

  a_full_free: assert property (@(posedge clk) disable iff (rst)
    state == S_UNDO |=> count == MAX_N)
    else $error("table-full back-out left wrong count");
`endif

endmodule

// ===== sim/bfa_checker.sv =====
// Checker for the best-fit free-extent allocator: watches the config, request and response
// channels, keeps its own extent table and compares every response. Depends on bfa_pkg.
`timescale 1ns / 1ps
module bfa_checker import bfa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [FIELD_W-1:0]   cfg_data,
  input  logic                 req_valid,
  input  logic                 req_ready,
  input  logic                 req_type,
  input  logic [FIELD_W-1:0]   start_page,
  input  logic [FIELD_W-1:0]   page_count,
  input  logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  logic [FIELD_W-1:0]   granted_page,
  input  logic [STATUS_W-1:0]  status,
  input  logic [6:0]           extent_count,
  output int                   errors,
  output int                   waiting,
  output int                   n_full,
  output int                   n_nofit
);
  localparam int NEXT = 64;
  localparam int SPACE = 65536;

  typedef struct packed {
    logic [FIELD_W-1:0]  page;
    logic [STATUS_W-1:0] st;
    logic [6:0]          cnt;
  } grant_t;

  int unsigned ext_s[0:NEXT];
  int unsigned ext_l[0:NEXT];
  int ext_n;
  grant_t grant_q[$];

  task automatic load_heap(input int unsigned pages);
    for (int k = 0; k <= NEXT; k++) begin
      ext_s[k] = 0;
      ext_l[k] = 0;
    end
    ext_l[0] = pages;
    ext_n = (pages != 0) ? 1 : 0;
  endtask

  // insert in address order, merge touching neighbors; false if too many extents
  function automatic bit add_extent(input int unsigned s, input int unsigned l);
    int unsigned ts[0:NEXT+1];
    int unsigned tl[0:NEXT+1];
    int n, i;
    bit placed;
    n = 0;
    i = 0;
    placed = 0;
    while (i < ext_n) begin
      if (!placed && ext_s[i] > s) begin
        ts[n] = s; tl[n] = l; n++; placed = 1;
      end else begin
        ts[n] = ext_s[i]; tl[n] = ext_l[i]; n++; i++;
      end
    end
    if (!placed) begin
      ts[n] = s; tl[n] = l; n++;
    end
    i = 0;
    while (i + 1 < n) begin
      if (ts[i] + tl[i] == ts[i+1]) begin
        tl[i] += tl[i+1];
        for (int k = i + 1; k + 1 < n; k++) begin
          ts[k] = ts[k+1];
          tl[k] = tl[k+1];
        end
        n--;
      end else begin
        i++;
      end
    end
    if (n > NEXT) return 0;
    for (int k = 0; k <= NEXT; k++) begin
      ext_s[k] = (k < n) ? ts[k] : 0;
      ext_l[k] = (k < n) ? tl[k] : 0;
    end
    ext_n = n;
    return 1;
  endfunction

  function automatic grant_t serve(input logic typ, input int unsigned sp,
                                   input int unsigned cnt);
    grant_t r;
    int best;
    int unsigned g, rem;
    r.page = '0;
    r.st = ST_OK;
    if (typ == 1'b0) begin
      best = -1;
      if (cnt != 0) begin
        for (int i = 0; i < ext_n; i++)
          if (ext_l[i] >= cnt && (best < 0 || ext_l[i] < ext_l[best])) best = i;
      end
      if (best < 0) begin
        r.st = ST_NOFIT;
      end else begin
        g = ext_s[best];
        rem = ext_l[best] - cnt;
        for (int i = best; i + 1 < ext_n; i++) begin
          ext_s[i] = ext_s[i+1];
          ext_l[i] = ext_l[i+1];
        end
        ext_n--;
        ext_s[ext_n] = 0;
        ext_l[ext_n] = 0;
        if (rem != 0) void'(add_extent(g + cnt, rem));
        r.page = g[FIELD_W-1:0];
      end
    end else begin
      if (cnt > SPACE - sp) cnt = SPACE - sp;
      if (cnt != 0 && !add_extent(sp, cnt)) r.st = ST_FULL;
    end
    r.cnt = ext_n[6:0];
    return r;
  endfunction

  assign waiting = grant_q.size();

  always @(posedge clk) begin
    grant_t e;
    if (rst) begin
      load_heap(32'(HEAP_RESET));
      grant_q.delete();
      errors <= 0;
      n_full <= 0;
      n_nofit <= 0;
    end else begin
      if (cfg_valid && cfg_ready) load_heap(32'(cfg_data));
      if (rsp_valid && rsp_ready) begin
        if (grant_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected response page=%0d status=%0d count=%0d",
                                    granted_page, status, extent_count);
        end else begin
          e = grant_q.pop_front();
          if (e.st == ST_FULL) n_full <= n_full + 1;
          if (e.st == ST_NOFIT) n_nofit <= n_nofit + 1;
          if (granted_page !== e.page || status !== e.st || extent_count !== e.cnt) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch at %0t: exp page=%0d status=%0d count=%0d, got %0d %0d %0d",
                       $realtime, e.page, e.st, e.cnt, granted_page, status, extent_count);
          end
        end
      end
      if (req_valid && req_ready)
        grant_q.push_back(serve(req_type, 32'(start_page), 32'(page_count)));
    end
  end
endmodule

// ===== sim/tb.sv =====
// Testbench top for best_fit_free_list_allocator: clock, reset, stimulus and verdict.
// Depends on bfa_pkg, the block and bfa_checker.
`timescale 1ns / 1ps
module tb;
  import bfa_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [FIELD_W-1:0] cfg_data = '0;
  logic req_valid = 0;
  logic req_ready;
  logic req_type = 0;
  logic [FIELD_W-1:0] start_page = '0;
  logic [FIELD_W-1:0] page_count = '0;
  logic rsp_valid;
  logic rsp_ready = 0;
  logic [FIELD_W-1:0] granted_page;
  logic [STATUS_W-1:0] status;
  logic [6:0] extent_count;
  int errors, waiting, n_full, n_nofit;

  int items = 0;
  int phases = 0;
  int idle_cycles = 0;
  bit hold_off = 0;
  bit no_gaps = 0;
  logic [FIELD_W:0] sent_q[$];   // {type, count} of items in flight
  logic [31:0] live_q[$];        // {start, count} of granted extents

  always #1 clk = ~clk;

  best_fit_free_list_allocator u_dut (.*);

  bfa_checker u_chk (.*);

  always @(posedge clk) begin
    logic [FIELD_W:0] s;
    if (!rst && rsp_valid && rsp_ready && sent_q.size() != 0) begin
      s = sent_q.pop_front();
      if (s[FIELD_W] == 1'b0 && status == ST_OK) live_q.push_back({granted_page, s[FIELD_W-1:0]});
    end
    if (!rst && req_valid && req_ready) sent_q.push_back({req_type, page_count});
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // response side
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        rsp_ready <= 0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      n = no_gaps ? 0 : $urandom_range(0, 18);
      if (n > 0) begin
        rsp_ready <= 0;
        repeat (n) @(posedge clk);
      end
      rsp_ready <= 1;
      do @(posedge clk); while (!(rsp_valid && rsp_ready));
    end
  end

  task automatic send(input logic typ, input logic [FIELD_W-1:0] sp,
                      input logic [FIELD_W-1:0] cnt);
    int n;
    n = no_gaps ? 0 : $urandom_range(0, 18);
    if (n > 0) begin
      req_valid <= 0;
      repeat (n) @(posedge clk);
    end
    req_valid <= 1;
    req_type <= typ;
    start_page <= sp;
    page_count <= cnt;
    do @(posedge clk); while (!req_ready);
    items++;
  endtask

  task automatic drain();
    req_valid <= 0;
    while (waiting != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_heap(input logic [FIELD_W-1:0] pages);
    drain();
    cfg_valid <= 1;
    cfg_data <= pages;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    live_q.delete();
    phases++;
  endtask

  task automatic random_items(input int n, input int max_cnt);
    logic [31:0] x;
    int k;
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      k = $urandom_range(0, 99);
      if (k < 45) begin
        send(0, 16'($urandom),
             (k < 3) ? 16'($urandom) : 16'($urandom_range(1, max_cnt)));
      end else if (k < 85 && live_q.size() != 0) begin
        k = $urandom_range(0, live_q.size() - 1);
        x = live_q[k];
        live_q.delete(k);
        send(1, x[31:16], x[15:0]);
      end else begin
        send(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed
    send(0, 16'hFFFF, 0);
    send(0, 0, 1);
    send(0, 0, 16'hFFFF);
    send(0, 0, 4095);
    send(0, 0, 1);
    send(1, 0, 0);
    send(1, 1, 4095);
    send(1, 0, 1);
    send(1, 16'hFFFF, 16'hFFFF);
    send(1, 16'hFFF0, 8);
    send(1, 100, 50);
    send(0, 0, 4096);
    set_heap(0);
    send(0, 0, 1);
    send(1, 10, 5);
    send(0, 0, 5);
    set_heap(1);
    for (int i = 1; i <= 66; i++) send(1, 16'(2 * i), 1);
    send(0, 0, 1);
    set_heap(16'hFFFF);
    send(0, 0, 16'hFFFF);
    send(1, 0, 16'hFFFF);
    set_heap(16'hFFFF);
    send(1, 16'hFFFF, 1);
    send(0, 0, 16'hFFFF);

    // random
    set_heap(4096);
    random_items(300, 64);
    hold_off = 1;
    random_items(300, 200);
    set_heap(16'hFFFF);
    random_items(400, 3000);
    set_heap(16'($urandom_range(1, 300)));
    random_items(400, 40);
    set_heap(16'h8000 | 16'($urandom_range(0, 16'h7FFF)));
    random_items(400, 16);

    drain();
    $display("%0d items over %0d heap settings; %0d no-fit and %0d table-full responses",
             items, phases, n_nofit, n_full);
    if (errors == 0 && waiting == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
